// File: rtl/refraction_direction_macros.svh
// Assertion macros shared by the refraction direction RTL.
`ifndef REFRACTION_DIRECTION_MACROS_SVH
`define REFRACTION_DIRECTION_MACROS_SVH

// Checked only while out of reset.
`define RFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define RFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rfd_pkg.sv
// Shared constants for the refraction direction block.
package rfd_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;  // vector component width, Q2.(W-2)
  localparam int INDEX_WIDTH         = 16;  // refractive index width, Q4.12

endpackage

// File: rtl/rfd_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module rfd_div_pipe #(
  parameter int NW = 32,  // numerator width
  parameter int DW = 16,  // divisor width
  parameter int QW = 17,  // quotient bits; num >> QW must be below den
  parameter int SW = 1    // sideband width
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_out,
  output logic [SW-1:0] side_out
);

  logic          vld    [QW+1];
  logic [DW-1:0] rem_s  [QW+1];
  logic [DW-1:0] den_s  [QW+1];
  logic [QW-1:0] lo_s   [QW+1];
  logic [SW-1:0] side_s [QW+1];

  assign vld[0]    = in_valid;
  assign rem_s[0]  = DW'(num[NW-1:QW]);
  assign den_s[0]  = den;
  assign lo_s[0]   = num[QW-1:0];
  assign side_s[0] = side_in;

  // lo_s shifts numerator bits out at the top and quotient bits in at the bottom
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_s[i], lo_s[i][QW-1]};
    assign diff  = trial - {1'b0, den_s[i]};
    assign ge    = trial >= {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        den_s[i+1]  <= den_s[i];
        lo_s[i+1]   <= {lo_s[i][QW-2:0], ge};
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = lo_s[QW];
  assign rem       = rem_s[QW];
  assign den_out   = den_s[QW];
  assign side_out  = side_s[QW];

endmodule

// File: rtl/rfd_isqrt_pipe.sv
// Pipelined floor square root, one root bit per stage, with a sideband.
module rfd_isqrt_pipe #(
  parameter int VW = 32,  // radicand width, even
  parameter int SW = 1    // sideband width
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [VW-1:0]   radicand,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [VW/2-1:0] root,
  output logic [SW-1:0]   side_out
);

  localparam int RW = VW / 2;

  logic          vld    [RW+1];
  logic [RW+1:0] rem_s  [RW+1];
  logic [RW-1:0] root_s [RW+1];
  logic [VW-1:0] v_s    [RW+1];
  logic [SW-1:0] side_s [RW+1];

  assign vld[0]    = in_valid;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign v_s[0]    = radicand;
  assign side_s[0] = side_in;

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RW+3:0] cur;
    logic [RW+3:0] tr;
    logic [RW+3:0] diff;
    logic          ge;

    assign cur  = {rem_s[i], v_s[i][VW-1:VW-2]};
    assign tr   = {2'b00, root_s[i], 2'b01};
    assign diff = cur - tr;
    assign ge   = cur >= tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
        root_s[i+1] <= {root_s[i][RW-2:0], ge};
        v_s[i+1]    <= v_s[i] << 2;
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = root_s[RW];
  assign side_out  = side_s[RW];

endmodule

// File: rtl/refraction_direction.sv
// Top level: pipelined Snell refraction of a unit direction about a unit normal.
//
// Accepts one ray per clock while the pipe advances and returns one result per
// ray, in order. With F = COMPONENT_WIDTH - 2 the latency is set by the
// bit-per-stage units in the path: the eta divider (F+17 stages), the sqrt(k)
// unit (F+8), the vector length sqrt (F+17) and the normalizing dividers
// (F+1), plus twelve arithmetic stages. The whole pipe advances when the
// output register is empty or being taken, so back-pressure stalls every
// stage together and nothing is dropped. is_transmitted is low, with a zero
// vector, for a zero transmitted index or total internal reflection.
`include "refraction_direction_macros.svh"

module refraction_direction #(
  parameter int COMPONENT_WIDTH = rfd_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // normal_x, normal_y, normal_z, incoming_x, incoming_y, incoming_z,
  // index_incident, index_transmitted (lowest bits first)
  input  logic [((6*COMPONENT_WIDTH+2*rfd_pkg::INDEX_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // out_x, out_y, out_z (lowest bits first)
  output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,
  // is_transmitted
  output logic m_tuser
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int IXW  = rfd_pkg::INDEX_WIDTH;
  localparam int F    = W - 2;
  localparam int SATW = F + 17;          // saturated intermediate, signed
  localparam int PW   = 2 * SATW;        // raw product
  localparam int OTW  = ((3*W+7)/8)*8;
  localparam logic signed [SATW-1:0] LIM   = {1'b0, {(SATW-1){1'b1}}};
  localparam logic signed [SATW+1:0] LIM_X = {3'b000, {(SATW-1){1'b1}}};
  localparam logic signed [SATW-1:0] ONE_V = SATW'(1) << F;
  localparam logic signed [W-1:0]    ONE_W = W'(1) << F;

  // eta divider
  localparam int NW_E = F + 18;
  localparam int QW_E = F + 17;
  localparam int SW_E = 6*W + SATW + 1;
  // sqrt(k)
  localparam int VW_K = 2*F + 16;
  localparam int RW_K = VW_K / 2;
  localparam int SW_K = 2*SATW + 6*W + 1;
  // vector length
  localparam int MW   = F + 16;          // |t|
  localparam int VW_L = 2*F + 34;
  localparam int SW_L = 3*MW + 4;
  // normalizing dividers
  localparam int NW_U = MW + F;
  localparam int QW_U = F + 1;

  function automatic logic signed [SATW-1:0] qmul(input logic signed [SATW-1:0] a,
                                                  input logic signed [SATW-1:0] b);
    logic [SATW-1:0] ma;
    logic [SATW-1:0] mb;
    logic [PW-1:0]   p;
    logic [PW-1:0]   r;
    logic [SATW-1:0] m;
    ma = a[SATW-1] ? -a : a;
    mb = b[SATW-1] ? -b : b;
    p  = PW'(ma) * PW'(mb);
    r  = (p + (PW'(1) << (F-1))) >> F;
    m  = (r > PW'(LIM)) ? LIM : r[SATW-1:0];
    qmul = (a[SATW-1] ^ b[SATW-1]) ? -m : m;
  endfunction

  function automatic logic signed [SATW-1:0] sat(input logic signed [SATW+1:0] x);
    logic signed [SATW-1:0] r;
    if (x > LIM_X) r = LIM;
    else if (x < -LIM_X) r = -LIM;
    else r = x[SATW-1:0];
    sat = r;
  endfunction

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic signed [W-1:0] nin [3];
  logic signed [W-1:0] din [3];
  logic [IXW-1:0] ni_in, nt_in;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign nin[i] = s_tdata[i*W +: W];
    assign din[i] = s_tdata[(3+i)*W +: W];
  end
  assign ni_in = s_tdata[6*W +: IXW];
  assign nt_in = s_tdata[6*W+IXW +: IXW];

  // stage 1: N.D products
  logic                   v1;
  logic signed [W-1:0]    n1 [3];
  logic signed [W-1:0]    d1 [3];
  logic signed [SATW-1:0] pnd1 [3];
  logic [IXW-1:0]         ni1, nt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n1[i]   <= nin[i];
        d1[i]   <= din[i];
        pnd1[i] <= qmul(SATW'(nin[i]), SATW'(din[i]));
      end
      ni1 <= ni_in;
      nt1 <= nt_in;
    end
  end

  // stage 2: cos term and eta numerator
  logic                   v2;
  logic signed [W-1:0]    n2 [3];
  logic signed [W-1:0]    d2 [3];
  logic signed [SATW-1:0] nid2;
  logic                   ntz2;
  logic [NW_E-1:0]        eta_num2;
  logic [IXW-1:0]         nt2;
  logic signed [SATW+1:0] dot_sum;

  assign dot_sum = (SATW+2)'(pnd1[0]) + (SATW+2)'(pnd1[1]) + (SATW+2)'(pnd1[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2       <= n1;
      d2       <= d1;
      nid2     <= -sat(dot_sum);
      ntz2     <= (nt1 == '0);
      eta_num2 <= (NW_E'(ni1) << F) + NW_E'(nt1[IXW-1:1]);
      nt2      <= nt1;
    end
  end

  logic                   ve;
  logic [QW_E-1:0]        eta_q;
  logic [SW_E-1:0]        e_side;
  logic signed [W-1:0]    ne [3];
  logic signed [W-1:0]    de [3];
  logic signed [SATW-1:0] nide;
  logic                   ntze;

  rfd_div_pipe #(.NW(NW_E), .DW(IXW), .QW(QW_E), .SW(SW_E)) u_eta_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v2),
    .num      (eta_num2),
    .den      (nt2),
    .side_in  ({n2[0], n2[1], n2[2], d2[0], d2[1], d2[2], nid2, ntz2}),
    .out_valid(ve),
    .quo      (eta_q),
    .rem      (),
    .den_out  (),
    .side_out (e_side)
  );
  assign {ne[0], ne[1], ne[2], de[0], de[1], de[2], nide, ntze} = e_side;

  // stage 3: clamp eta, cos^2
  logic                   v3, ntz3;
  logic signed [W-1:0]    n3 [3];
  logic signed [W-1:0]    d3 [3];
  logic signed [SATW-1:0] eta3, nid3, m1_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n3   <= ne;
      d3   <= de;
      ntz3 <= ntze;
      nid3 <= nide;
      eta3 <= eta_q[QW_E-1] ? LIM : $signed(eta_q);
      m1_3 <= qmul(nide, nide);
    end
  end

  // stage 4: 1 - cos^2, eta^2, eta*cos
  logic                   v4, ntz4;
  logic signed [W-1:0]    n4 [3];
  logic signed [W-1:0]    d4 [3];
  logic signed [SATW-1:0] a4, e2_4, ec4, eta4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n4   <= n3;
      d4   <= d3;
      ntz4 <= ntz3;
      eta4 <= eta3;
      a4   <= sat((SATW+2)'(ONE_V) - (SATW+2)'(m1_3));
      e2_4 <= qmul(eta3, eta3);
      ec4  <= qmul(eta3, nid3);
    end
  end

  // stage 5: eta^2 (1 - cos^2)
  logic                   v5, ntz5;
  logic signed [W-1:0]    n5 [3];
  logic signed [W-1:0]    d5 [3];
  logic signed [SATW-1:0] m2_5, ec5, eta5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n5   <= n4;
      d5   <= d4;
      ntz5 <= ntz4;
      eta5 <= eta4;
      ec5  <= ec4;
      m2_5 <= qmul(e2_4, a4);
    end
  end

  // stage 6: discriminant k
  logic                   v6, ok6;
  logic signed [W-1:0]    n6 [3];
  logic signed [W-1:0]    d6 [3];
  logic signed [SATW-1:0] ec6, eta6, k5;
  logic [MW-1:0]          k6;

  assign k5 = sat((SATW+2)'(ONE_V) - (SATW+2)'(m2_5));

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n6   <= n5;
      d6   <= d5;
      eta6 <= eta5;
      ec6  <= ec5;
      ok6  <= !ntz5 && !k5[SATW-1];
      k6   <= k5[SATW-1] ? '0 : k5[MW-1:0];
    end
  end

  logic                   vk;
  logic [RW_K-1:0]        s_root;
  logic [SW_K-1:0]        k_side;
  logic signed [W-1:0]    nk [3];
  logic signed [W-1:0]    dk [3];
  logic signed [SATW-1:0] eck, etak;
  logic                   okk;

  rfd_isqrt_pipe #(.VW(VW_K), .SW(SW_K)) u_k_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v6),
    .radicand ({k6, F'(0)}),
    .side_in  ({ec6, eta6, n6[0], n6[1], n6[2], d6[0], d6[1], d6[2], ok6}),
    .out_valid(vk),
    .root     (s_root),
    .side_out (k_side)
  );
  assign {eck, etak, nk[0], nk[1], nk[2], dk[0], dk[1], dk[2], okk} = k_side;

  // stage 7: normal scale c = eta*cos - sqrt(k)
  logic                   v7, ok7;
  logic signed [W-1:0]    n7 [3];
  logic signed [W-1:0]    d7 [3];
  logic signed [SATW-1:0] c7, eta7;
  logic signed [SATW+1:0] cdiff;

  assign cdiff = (SATW+2)'(eck) - $signed((SATW+2)'(s_root));

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= vk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n7   <= nk;
      d7   <= dk;
      eta7 <= etak;
      ok7  <= okk;
      c7   <= sat(cdiff);
    end
  end

  // stage 8: N*c and D*eta per lane
  logic                   v8, ok8;
  logic signed [SATW-1:0] qa8 [3];
  logic signed [SATW-1:0] qb8 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok8 <= ok7;
      for (int i = 0; i < 3; i++) begin
        qa8[i] <= qmul(SATW'(n7[i]), c7);
        qb8[i] <= qmul(SATW'(d7[i]), eta7);
      end
    end
  end

  // stage 9: refracted vector T, kept as sign and magnitude
  logic                   v9, ok9;
  logic [MW-1:0]          tm9 [3];
  logic                   ts9 [3];
  logic signed [SATW-1:0] t8 [3];
  logic [SATW-1:0]        tabs8 [3];

  for (genvar i = 0; i < 3; i++) begin : g_t
    assign t8[i]    = sat((SATW+2)'(qa8[i]) + (SATW+2)'(qb8[i]));
    assign tabs8[i] = t8[i][SATW-1] ? -t8[i] : t8[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok9 <= ok8;
      for (int i = 0; i < 3; i++) begin
        tm9[i] <= tabs8[i][MW-1:0];
        ts9[i] <= t8[i][SATW-1];
      end
    end
  end

  // stage 10: squares
  logic                v10, ok10;
  logic [MW-1:0]       tm10 [3];
  logic                ts10 [3];
  logic [2*MW-1:0]     sq10 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok10 <= ok9;
      tm10 <= tm9;
      ts10 <= ts9;
      for (int i = 0; i < 3; i++) begin
        sq10[i] <= (2*MW)'(tm9[i]) * (2*MW)'(tm9[i]);
      end
    end
  end

  // stage 11: |T|^2
  logic            v11, ok11;
  logic [MW-1:0]   tm11 [3];
  logic            ts11 [3];
  logic [VW_L-1:0] len2_11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (adv) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok11    <= ok10;
      tm11    <= tm10;
      ts11    <= ts10;
      len2_11 <= VW_L'(sq10[0]) + VW_L'(sq10[1]) + VW_L'(sq10[2]);
    end
  end

  logic            vl, okl;
  logic [SATW-1:0] len;
  logic [SW_L-1:0] l_side;
  logic [MW-1:0]   tml [3];
  logic            tsl [3];

  rfd_isqrt_pipe #(.VW(VW_L), .SW(SW_L)) u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v11),
    .radicand (len2_11),
    .side_in  ({tm11[0], tm11[1], tm11[2], ts11[0], ts11[1], ts11[2], ok11}),
    .out_valid(vl),
    .root     (len),
    .side_out (l_side)
  );
  assign {tml[0], tml[1], tml[2], tsl[0], tsl[1], tsl[2], okl} = l_side;

  // normalize: |t| * 2^F / |T| per lane; lane 0 carries the flag
  logic            vu;
  logic [QW_U-1:0] uq   [3];
  logic [SATW-1:0] urem [3];
  logic [SATW-1:0] uden [3];
  logic            usgn [3];
  logic            uok;

  rfd_div_pipe #(.NW(NW_U), .DW(SATW), .QW(QW_U), .SW(2)) u_norm_div0 (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vl),
    .num      ({tml[0], F'(0)}),
    .den      (len),
    .side_in  ({tsl[0], okl}),
    .out_valid(vu),
    .quo      (uq[0]),
    .rem      (urem[0]),
    .den_out  (uden[0]),
    .side_out ({usgn[0], uok})
  );

  for (genvar i = 1; i < 3; i++) begin : g_norm
    rfd_div_pipe #(.NW(NW_U), .DW(SATW), .QW(QW_U), .SW(1)) u_norm_div (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (vl),
      .num      ({tml[i], F'(0)}),
      .den      (len),
      .side_in  (tsl[i]),
      .out_valid(),
      .quo      (uq[i]),
      .rem      (urem[i]),
      .den_out  (uden[i]),
      .side_out (usgn[i])
    );
  end

  // output register: round, restore sign, zero when nothing is transmitted
  logic signed [W-1:0] out_c  [3];
  logic signed [W-1:0] out_r  [3];
  logic                tx;
  logic                len_nz;

  assign len_nz = (uden[0] != '0);

  for (genvar i = 0; i < 3; i++) begin : g_round
    logic            up;
    logic [QW_U-1:0] qr;
    assign up       = {urem[i], 1'b0} >= {1'b0, uden[i]};
    assign qr       = uq[i] + QW_U'(up);
    assign out_c[i] = !(uok && len_nz) ? '0 : (usgn[i] ? -W'(qr) : W'(qr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vu;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_c;
      tx    <= uok;
    end
  end

  assign m_tdata = OTW'({out_r[2], out_r[1], out_r[0]});
  assign m_tuser = tx;

  `RFD_ASSERT(a_blocked_is_zero, m_tvalid && !tx |-> out_r[0] == '0 && out_r[1] == '0 && out_r[2] == '0, "blocked ray with nonzero vector")
  `RFD_ASSERT(a_unit_bound, m_tvalid && tx |-> out_r[0] <= ONE_W && out_r[0] >= -ONE_W && out_r[2] <= ONE_W && out_r[2] >= -ONE_W, "normalized component above one")
  `RFD_ASSERT(a_stall_holds, !adv |=> $stable(v1) && $stable(v11) && $stable(m_tvalid), "pipe moved during stall")
  `RFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && !v1, "pipe not empty after reset")

endmodule
